>>> hw/rtl/ecm_pkg.sv
// ----------------------------------------------------------------------------
// Effect crossfade mixer package
// Shared types, codes and fixed-point constants of the crossfade mixer.
// ----------------------------------------------------------------------------
package ecm_pkg;

  localparam int unsigned ID_BITS     = 8;
  localparam int unsigned STEP_W      = 17;
  localparam int unsigned LEVEL_W     = 17;
  localparam int unsigned BRIGHT_W    = 17;
  localparam int unsigned DUR_W       = 23;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned ACC_W       = 51;
  localparam int unsigned SUM_W       = 52;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned DCNT_W      = 4;
  localparam int unsigned CFG_DATA_W  = 23;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [LEVEL_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [DUR_W-1:0]   MAX_DURATION = 23'h400000;
  localparam logic [DUR_W-1:0]   PROGRESS_MAX = 23'h7FFFFF;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SWITCH = 2'd1,
    MODE_ENABLE = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    NOTE_NONE = 2'd0,
    NOTE_ON   = 2'd1,
    NOTE_OFF  = 2'd2
  } note_e;

  typedef enum logic {
    REG_BRIGHTNESS = 1'b0,
    REG_DURATION   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LL,
    S_BW,
    S_DIV,
    S_WT,
    S_W1,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/effect_crossfade_mixer.sv
// Weights come from a shift-add multiplier that retires one multiplier bit per cycle (three
// products) and a restoring divider that retires one quotient bit per cycle. A new item
// is accepted only while idle, once the last result has gone to the output register; a
// finished result may wait there while the next item is accepted. Reset clears levels,
// flags, counts and the output valid.
// ----------------------------------------------------------------------------
// Effect crossfade mixer
// Fade level and effect queue, and crossfade weights computed over one shared adder.
// ----------------------------------------------------------------------------
module effect_crossfade_mixer #(
  parameter int unsigned QUEUE_DEPTH = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: time_step[16:0], effect_id[24:17], enable_value[25], zero fill
  input  logic [ecm_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // tuser: mode[1:0]
  input  logic [1:0]                          s_axis_tuser_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: first_effect[7:0], first_valid[8], first_weight[25:9],
  //        second_effect[33:26], second_valid[34], second_weight[51:35],
  //        notify[53:52], zero fill
  output logic [ecm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [ecm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ecm_pkg::ID_BITS-1:0] id_t;

  ecm_pkg::state_e state_q, state_d;

  logic [ecm_pkg::BRIGHT_W-1:0] bright_q;
  logic [ecm_pkg::DUR_W-1:0]    dur_q;

  id_t                         queue_q [QUEUE_DEPTH];
  id_t                         queue_n [QUEUE_DEPTH];
  logic [CNT_W-1:0]            cnt_q, cnt_n;
  logic                        flag_q, flag_n;
  logic [ecm_pkg::LEVEL_W-1:0] level_q, level_n;
  logic [ecm_pkg::DUR_W-1:0]   prog_q, prog_n;
  ecm_pkg::note_e              note_q, note_n;

  logic [ecm_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [ecm_pkg::ACC_W-1:0]    mcand_q, mcand_d;
  logic [ecm_pkg::LEVEL_W-1:0]  mplier_q, mplier_d;
  logic [ecm_pkg::WEIGHT_W-1:0] w_q, w_d;
  logic [ecm_pkg::FRAC_W-1:0]   t_q, t_d;
  logic [ecm_pkg::DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [ecm_pkg::WEIGHT_W-1:0] w1_q, w1_d;
  logic [ecm_pkg::WEIGHT_W-1:0] w2_q, w2_d;

  logic [ecm_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                            out_valid_q, out_valid_d;

  logic [ecm_pkg::SUM_W-1:0] add_a, add_b, add_sum;
  logic                      add_cin;

  logic                         in_fire;
  ecm_pkg::mode_e               in_mode;
  logic [ecm_pkg::STEP_W-1:0]   in_step;
  id_t                          in_id;
  logic                         in_en;
  logic [IDX_W-1:0]             last_idx;
  logic [ecm_pkg::LEVEL_W:0]    level_sum;
  logic [ecm_pkg::DUR_W:0]      prog_sum;
  logic [ecm_pkg::DUR_W-1:0]    prog_sat;
  logic [ecm_pkg::DUR_W:0]      rem_sh;
  logic                         qbit;
  logic                         load_out;
  logic [ecm_pkg::WEIGHT_W-1:0] w_full;
  logic                         one_present, two_present;

  assign in_mode  = ecm_pkg::mode_e'(s_axis_tuser_i);
  assign in_step  = s_axis_tdata_i[16:0];
  assign in_id    = s_axis_tdata_i[24:17];
  assign in_en    = s_axis_tdata_i[25];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign last_idx = IDX_W'(cnt_q - CNT_W'(1));

  assign s_axis_tready_o = (state_q == ecm_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Item state update on the input transfer
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_n[i] = queue_q[i];
    end
    cnt_n     = cnt_q;
    flag_n    = flag_q;
    level_n   = level_q;
    prog_n    = prog_q;
    note_n    = ecm_pkg::NOTE_NONE;
    level_sum = {1'b0, level_q} + {1'b0, in_step};
    prog_sum  = {1'b0, prog_q} + (ecm_pkg::DUR_W + 1)'(in_step);
    prog_sat  = prog_sum[ecm_pkg::DUR_W] ? ecm_pkg::PROGRESS_MAX
                                         : prog_sum[ecm_pkg::DUR_W-1:0];
    unique case (in_mode)
      ecm_pkg::MODE_TICK: begin
        if (flag_q) begin
          if (level_q < ecm_pkg::ONE_Q16) begin
            level_n = (level_sum > {1'b0, ecm_pkg::ONE_Q16}) ? ecm_pkg::ONE_Q16
                                                           : level_sum[16:0];
          end
        end else if (level_q != '0) begin
          if (in_step >= level_q) begin
            level_n = '0;
            note_n  = ecm_pkg::NOTE_OFF;
          end else begin
            level_n = level_q - in_step;
          end
        end
        if (cnt_q >= CNT_W'(2)) begin
          prog_n = prog_sat;
          if (prog_sat >= dur_q) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              queue_n[i] = queue_q[i+1];
            end
            cnt_n  = cnt_q - CNT_W'(1);
            prog_n = (cnt_q == CNT_W'(2)) ? '0 : prog_sat - dur_q;
          end
        end
      end
      ecm_pkg::MODE_SWITCH: begin
        if (cnt_q >= CNT_W'(QUEUE_DEPTH)) begin
          queue_n[QUEUE_DEPTH-1] = in_id;
        end else if (cnt_q == '0 || queue_q[last_idx] != in_id) begin
          queue_n[IDX_W'(cnt_q)] = in_id;
          cnt_n = cnt_q + CNT_W'(1);
        end
      end
      ecm_pkg::MODE_ENABLE: begin
        flag_n = in_en;
        if (in_en && level_q == '0) begin
          note_n = ecm_pkg::NOTE_ON;
        end
      end
      default: begin
      end
    endcase
  end

  // Shared adder
  assign add_sum = add_a + add_b + ecm_pkg::SUM_W'(add_cin);
  assign rem_sh  = {acc_q[ecm_pkg::DUR_W-1:0], 1'b0};
  assign qbit    = ~add_sum[ecm_pkg::SUM_W-1];
  assign w_full  = acc_q[48:32];

  assign one_present = (cnt_q >= CNT_W'(1));
  assign two_present = (cnt_q >= CNT_W'(2));

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      ecm_pkg::S_LL, ecm_pkg::S_BW, ecm_pkg::S_WT: begin
        add_a = {1'b0, acc_q};
        add_b = mplier_q[0] ? {1'b0, mcand_q} : '0;
      end
      ecm_pkg::S_DIV: begin
        add_a   = ecm_pkg::SUM_W'(rem_sh);
        add_b   = ~ecm_pkg::SUM_W'(dur_q);
        add_cin = 1'b1;
      end
      ecm_pkg::S_W1: begin
        add_a   = ecm_pkg::SUM_W'(w_q);
        add_b   = ~ecm_pkg::SUM_W'(w2_q);
        add_cin = (acc_q[ecm_pkg::FRAC_W-1:0] == '0);
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    w_d      = w_q;
    t_d      = t_q;
    dcnt_d   = dcnt_q;
    w1_d     = w1_q;
    w2_d     = w2_q;
    load_out = 1'b0;
    unique case (state_q)
      ecm_pkg::S_IDLE: begin
        if (in_fire) begin
          acc_d    = '0;
          mcand_d  = ecm_pkg::ACC_W'(level_n);
          mplier_d = level_n;
          state_d  = ecm_pkg::S_LL;
        end
      end
      ecm_pkg::S_LL, ecm_pkg::S_BW, ecm_pkg::S_WT: begin
        if (mplier_q == '0) begin
          if (state_q == ecm_pkg::S_LL) begin
            acc_d    = '0;
            mcand_d  = ecm_pkg::ACC_W'(acc_q[33:0]);
            mplier_d = bright_q;
            state_d  = ecm_pkg::S_BW;
          end else if (state_q == ecm_pkg::S_BW) begin
            w_d = w_full;
            if (!one_present) begin
              w1_d    = '0;
              w2_d    = '0;
              state_d = ecm_pkg::S_DONE;
            end else if (!two_present) begin
              w1_d    = w_full;
              w2_d    = '0;
              state_d = ecm_pkg::S_DONE;
            end else if (prog_q >= dur_q) begin
              w1_d    = '0;
              w2_d    = w_full;
              state_d = ecm_pkg::S_DONE;
            end else begin
              acc_d   = ecm_pkg::ACC_W'(prog_q);
              t_d     = '0;
              dcnt_d  = '0;
              state_d = ecm_pkg::S_DIV;
            end
          end else begin
            w2_d    = acc_q[32:16];
            state_d = ecm_pkg::S_W1;
          end
        end else begin
          if (mplier_q[0]) begin
            acc_d = add_sum[ecm_pkg::ACC_W-1:0];
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      ecm_pkg::S_DIV: begin
        acc_d  = qbit ? ecm_pkg::ACC_W'(add_sum[ecm_pkg::DUR_W-1:0])
                      : ecm_pkg::ACC_W'(rem_sh);
        t_d    = {t_q[ecm_pkg::FRAC_W-2:0], qbit};
        dcnt_d = dcnt_q + ecm_pkg::DCNT_W'(1);
        if (dcnt_q == ecm_pkg::DCNT_W'(ecm_pkg::DIV_STEPS - 1)) begin
          acc_d    = '0;
          mcand_d  = ecm_pkg::ACC_W'(w_q);
          mplier_d = {1'b0, t_d};
          state_d  = ecm_pkg::S_WT;
        end
      end
      ecm_pkg::S_W1: begin
        w1_d    = add_sum[ecm_pkg::WEIGHT_W-1:0];
        state_d = ecm_pkg::S_DONE;
      end
      ecm_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ecm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ecm_pkg::S_IDLE;
      end
    endcase
  end

  // Result assembly
  always_comb begin
    out_data_d = out_data_q;
    if (load_out) begin
      out_data_d = {2'b00, note_q, w2_q, two_present,
                    two_present ? queue_q[1] : id_t'(0),
                    w1_q, one_present,
                    one_present ? queue_q[0] : id_t'(0)};
    end
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecm_pkg::S_IDLE;
      bright_q    <= ecm_pkg::ONE_Q16;
      dur_q       <= ecm_pkg::DUR_W'(ecm_pkg::ONE_Q16);
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      level_q     <= '0;
      prog_q      <= '0;
      note_q      <= ecm_pkg::NOTE_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        cnt_q   <= cnt_n;
        flag_q  <= flag_n;
        level_q <= level_n;
        prog_q  <= prog_n;
        note_q  <= note_n;
      end
      if (cfg_we_i) begin
        unique case (ecm_pkg::reg_idx_e'(cfg_idx_i))
          ecm_pkg::REG_BRIGHTNESS: begin
            bright_q <= (cfg_data_i[16:0] > ecm_pkg::ONE_Q16) ? ecm_pkg::ONE_Q16
                                                              : cfg_data_i[16:0];
          end
          ecm_pkg::REG_DURATION: begin
            dur_q <= (cfg_data_i > ecm_pkg::MAX_DURATION) ? ecm_pkg::MAX_DURATION
                                                          : cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        queue_q[i] <= queue_n[i];
      end
    end
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    w_q        <= w_d;
    t_q        <= t_d;
    dcnt_q     <= dcnt_d;
    w1_q       <= w1_d;
    w2_q       <= w2_d;
    out_data_q <= out_data_d;
  end

endmodule

>>> bench/tb_effect_crossfade_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effect crossfade mixer testbench
// Drives mode/step/id/enable items into the mixer over the input stream and
// predicts every result from a cycle-free model of the fade level, the effect
// queue and the crossfade weights. Checks each output transfer field by field
// under random stalls on both sides, across brightness and duration settings.
// ----------------------------------------------------------------------------
module tb_effect_crossfade_mixer;

  localparam int FX_DEPTH    = 3;
  localparam int LATENCY_GAP = 80;

  typedef struct packed {
    logic [7:0]  first_effect;
    logic        first_valid;
    logic [16:0] first_weight;
    logic [7:0]  second_effect;
    logic        second_valid;
    logic [16:0] second_weight;
    logic [1:0]  notify;
  } mix_result_t;

  logic                             clk;
  logic                             rst_n    = 1'b0;
  logic [ecm_pkg::IN_TDATA_W-1:0]   s_tdata  = '0;
  logic [1:0]                       s_tuser  = ecm_pkg::MODE_HOLD;
  logic                             s_valid  = 1'b0;
  logic                             m_ready  = 1'b0;
  logic                             cfg_we   = 1'b0;
  ecm_pkg::reg_idx_e                cfg_idx  = ecm_pkg::REG_BRIGHTNESS;
  logic [ecm_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                             s_axis_tready_o;
  logic [ecm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                             m_axis_tvalid_o;

  // predictor state
  logic [16:0] mix_bright   = ecm_pkg::ONE_Q16;
  logic [22:0] mix_dur      = 23'h10000;
  logic [16:0] mix_level    = '0;
  logic [22:0] mix_progress = '0;
  logic [7:0]  mix_ids[FX_DEPTH] = '{default: '0};
  int          mix_count    = 0;
  logic        mix_enabled  = 1'b0;

  mix_result_t mix_expected[$];
  int          fail_count = 0;
  int          rx_hold    = 0;
  bit          calm       = 1'b0;

  effect_crossfade_mixer #(.QUEUE_DEPTH(FX_DEPTH)) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_effect_crossfade_mixer: FAIL");
    $finish;
  end

  function automatic mix_result_t mix_apply(input ecm_pkg::mode_e mode,
                                            input logic [16:0] step,
                                            input logic [7:0] id, input logic en);
    mix_result_t r;
    logic [63:0] acc;
    logic [63:0] w;
    logic [63:0] t;
    r = '0;
    t = 0;
    case (mode)
      ecm_pkg::MODE_TICK: begin
        if (mix_enabled) begin
          if (mix_level < ecm_pkg::ONE_Q16) begin
            acc = mix_level + step;
            mix_level = (acc > ecm_pkg::ONE_Q16) ? ecm_pkg::ONE_Q16 : acc[16:0];
          end
        end else if (mix_level != 0) begin
          if (step >= mix_level) begin
            mix_level = '0;
            r.notify = ecm_pkg::NOTE_OFF;
          end else begin
            mix_level = mix_level - step;
          end
        end
        if (mix_count >= 2) begin
          acc = mix_progress + step;
          mix_progress = (acc > ecm_pkg::PROGRESS_MAX) ? ecm_pkg::PROGRESS_MAX
                                                       : acc[22:0];
          if (mix_progress >= mix_dur) begin
            mix_ids[0] = mix_ids[1];
            mix_ids[1] = mix_ids[2];
            mix_count--;
            mix_progress = mix_progress - mix_dur;
            if (mix_count == 1) mix_progress = '0;
          end
        end
      end
      ecm_pkg::MODE_SWITCH: begin
        if (mix_count >= FX_DEPTH) begin
          mix_ids[FX_DEPTH-1] = id;
        end else if (mix_count == 0 || mix_ids[mix_count-1] != id) begin
          mix_ids[mix_count] = id;
          mix_count++;
        end
      end
      ecm_pkg::MODE_ENABLE: begin
        mix_enabled = en;
        if (en && mix_level == 0) r.notify = ecm_pkg::NOTE_ON;
      end
      default: ;
    endcase

    w = (64'(mix_bright) * mix_level * mix_level) >> 32;
    if (mix_count >= 2) begin
      if (mix_dur == 0) begin
        t = 65536;
      end else begin
        t = (64'(mix_progress) << 16) / mix_dur;
        if (t > 65536) t = 65536;
      end
    end
    if (mix_count >= 1) begin
      r.first_effect = mix_ids[0];
      r.first_valid  = 1'b1;
      r.first_weight = 17'((w * (65536 - t)) >> 16);
    end
    if (mix_count >= 2) begin
      r.second_effect = mix_ids[1];
      r.second_valid  = 1'b1;
      r.second_weight = 17'((w * t) >> 16);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_mix(input logic [ecm_pkg::OUT_TDATA_W-1:0] d);
    mix_result_t e;
    if (mix_expected.size() == 0) begin
      $error("unexpected result transfer: %h", d);
      fail_count++;
    end else begin
      e = mix_expected[0];
      mix_expected.delete(0);
      compare_field("first_effect",  e.first_effect,  d[7:0]);
      compare_field("first_valid",   e.first_valid,   d[8]);
      compare_field("first_weight",  e.first_weight,  d[25:9]);
      compare_field("second_effect", e.second_effect, d[33:26]);
      compare_field("second_valid",  e.second_valid,  d[34]);
      compare_field("second_weight", e.second_weight, d[51:35]);
      compare_field("notify",        e.notify,        d[53:52]);
    end
  endtask

  // receiver: check, then pick ready for the next edge
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid_o === 1'b1 && m_ready) check_mix(m_axis_tdata_o);
    if (rx_hold > 0) begin
      m_ready <= 1'b0;
      rx_hold--;
    end else begin
      m_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  task automatic send_item(input ecm_pkg::mode_e mode, input logic [16:0] step,
                           input logic [7:0] id, input logic en);
    if (!calm && $urandom_range(99) < 11) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    s_tdata <= {6'd0, en, id, step};
    s_tuser <= mode;
    s_valid <= 1'b1;
    do @(posedge clk); while (s_axis_tready_o !== 1'b1);
    mix_expected.push_back(mix_apply(mode, step, id, en));
  endtask

  task automatic send_random_item();
    ecm_pkg::mode_e mode;
    logic [16:0]    step;
    logic [7:0]     id;
    int             pick;
    pick = $urandom_range(99);
    if (pick < 55)      mode = ecm_pkg::MODE_TICK;
    else if (pick < 72) mode = ecm_pkg::MODE_SWITCH;
    else if (pick < 92) mode = ecm_pkg::MODE_ENABLE;
    else                mode = ecm_pkg::MODE_HOLD;
    case ($urandom_range(9))
      0:       step = '0;
      1:       step = 17'h10000;
      2, 3, 4: step = 17'($urandom_range(0, 65536));
      default: step = 17'($urandom_range(0, 4096));
    endcase
    id = 8'($urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
    send_item(mode, step, id, $urandom_range(3) != 0);
  endtask

  task automatic wait_mix_idle();
    s_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (LATENCY_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(input ecm_pkg::reg_idx_e idx,
                           input logic [ecm_pkg::CFG_DATA_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == ecm_pkg::REG_BRIGHTNESS) begin
      mix_bright = (v[16:0] > ecm_pkg::ONE_Q16) ? ecm_pkg::ONE_Q16 : v[16:0];
    end else begin
      mix_dur = (v > ecm_pkg::MAX_DURATION) ? ecm_pkg::MAX_DURATION : v;
    end
  endtask

  task automatic set_mix_config(input logic [ecm_pkg::CFG_DATA_W-1:0] b,
                                input logic [ecm_pkg::CFG_DATA_W-1:0] d);
    wait_mix_idle();
    cfg_write(ecm_pkg::REG_BRIGHTNESS, b);
    cfg_write(ecm_pkg::REG_DURATION, d);
  endtask

  task automatic test_directed();
    send_item(ecm_pkg::MODE_HOLD,   17'd0,     8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'h10000, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_ENABLE, 17'd0,     8'd0,   1'b1);
    send_item(ecm_pkg::MODE_ENABLE, 17'd0,     8'd0,   1'b1);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'd0,     8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'h10000, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'd0,   1'b0);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'hFF,  1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'd16384, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'hA5,  1'b0);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'h5A,  1'b0);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'h5A,  1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'h10000, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_HOLD,   17'h1FFFF, 8'hFF,  1'b1);
    send_item(ecm_pkg::MODE_TICK,   17'h10000, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'd1,     8'd0,   1'b0);
    send_item(ecm_pkg::MODE_ENABLE, 17'd0,     8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'd1000,  8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'd65535, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'h10000, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_ENABLE, 17'd0,     8'd0,   1'b1);
    send_item(ecm_pkg::MODE_TICK,   17'd30000, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_ENABLE, 17'd0,     8'd0,   1'b0);
    send_item(ecm_pkg::MODE_TICK,   17'd100,   8'd0,   1'b0);
  endtask

  // crossfade left far past a duration that is then cut short
  task automatic test_duration_cut();
    set_mix_config(23'h10000, ecm_pkg::MAX_DURATION);
    send_item(ecm_pkg::MODE_ENABLE, 17'd0,     8'd0,   1'b1);
    send_item(ecm_pkg::MODE_TICK,   17'h10000, 8'd0,   1'b0);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'h11,  1'b0);
    send_item(ecm_pkg::MODE_SWITCH, 17'd0,     8'h22,  1'b0);
    repeat (3) send_item(ecm_pkg::MODE_TICK, 17'h10000, 8'd0, 1'b0);
    wait_mix_idle();
    cfg_write(ecm_pkg::REG_DURATION, 23'd1000);
    send_item(ecm_pkg::MODE_HOLD, 17'd0, 8'd0, 1'b0);
    send_item(ecm_pkg::MODE_TICK, 17'd0, 8'd0, 1'b0);
    send_item(ecm_pkg::MODE_HOLD, 17'd0, 8'd0, 1'b0);
  endtask

  task automatic test_config_extremes();
    set_mix_config(23'd0, 23'h10000);
    repeat (60) send_random_item();
    set_mix_config(23'h10000, 23'd0);
    repeat (60) send_random_item();
    set_mix_config(23'h7FFFFF, 23'h7FFFFF);
    repeat (60) send_random_item();
    set_mix_config(23'h10000, 23'd1);
    repeat (60) send_random_item();
    set_mix_config(23'd32768, 23'd300);
    repeat (60) send_random_item();
    set_mix_config(23'h10000, ecm_pkg::MAX_DURATION);
    repeat (60) send_random_item();
  endtask

  task automatic test_output_stall();
    set_mix_config(23'h10000, 23'd20000);
    rx_hold = 400;
    repeat (40) send_random_item();
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      repeat (20) send_random_item();
      wait_mix_idle();
    end
  endtask

  task automatic test_random();
    logic [ecm_pkg::CFG_DATA_W-1:0] b;
    logic [ecm_pkg::CFG_DATA_W-1:0] d;
    for (int phase = 0; phase < 11; phase++) begin
      case ($urandom_range(3))
        0:       b = 23'h10000;
        1:       b = 23'($urandom_range(0, 65536));
        2:       b = 23'($urandom_range(0, 23'h7FFFFF));
        default: b = 23'($urandom_range(30000, 65536));
      endcase
      case ($urandom_range(4))
        0:       d = 23'($urandom_range(0, 2000));
        1:       d = 23'($urandom_range(0, 262144));
        2:       d = 23'h10000;
        3:       d = 23'($urandom_range(0, 23'h7FFFFF));
        default: d = '0;
      endcase
      set_mix_config(b, d);
      calm = (phase == 5);
      repeat (calm ? 60 : 38) send_random_item();
      wait_mix_idle();
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_duration_cut();
    test_config_extremes();
    test_output_stall();
    test_sender_pause();
    test_random();
    wait_mix_idle();
    if (fail_count == 0) begin
      $display("tb_effect_crossfade_mixer: PASS");
    end else begin
      $display("tb_effect_crossfade_mixer: FAIL");
    end
    $finish;
  end

endmodule
